// ===== rtl/core/grdws_pkg.sv =====
package grdws_pkg;
    localparam int SampleBitsDef = 12;
    localparam int MaxFramesDef  = 4096;
    localparam int NumCh         = 6;
    localparam int ChDiff        = 4;
    localparam int ChTemp        = 5;
    localparam int ValBits       = 13;
    localparam int CfgBits       = 13;
    localparam logic [0:0] RegTxThreshold = 1'b0;
    localparam logic [0:0] RegMinGated    = 1'b1;

    typedef struct packed {
        logic clear;
        logic accum;
        logic div_start;
        logic [2:0] sel;
    } grdws_cmd_t;

    typedef struct packed {
        logic div_done;
    } grdws_sts_t;
endpackage

// ===== rtl/core/gated_rf_detector_window_stats.sv =====
// channel | dir | tdata fields (low bit up)                            | tuser / tlast
// s_      | in  | fwd, pos, neg, rev, temp (12b each)                  | tlast=last_frame
// m_      | out | min, max, avg (13b signed), sample_count (13b)       | tuser=channel,valid; tlast
// Accumulation: one frame per cycle while no window is being reported.
// Window close: the six channels are divided and reported in turn (sum-by-count restoring shift divider).
// Input ready is low from the last frame until the sixth result is loaded.
// Output register holds a result until taken; stalls back up into the divider sequence.
// Reset (aresetn low, synchronous) clears statistics and restores register defaults.
module gated_rf_detector_window_stats import grdws_pkg::*; #(
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int MAX_FRAMES  = MaxFramesDef
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_addr,
    input  logic [CfgBits-1:0]        cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // fwd,pos,neg,rev,temp
    input  logic                      s_tlast,   // last_frame
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,   // min,max,avg,sample_count
    output logic [3:0]                m_tuser,   // channel, window_valid
    output logic                      m_tlast    // last_result
);
    localparam int W = SAMPLE_BITS;
    logic [11:0]         thr_reg;
    logic [CfgBits-1:0]  mg_reg;
    grdws_cmd_t          cmd;
    grdws_sts_t          sts;
    logic                in_fire, out_load, out_free;
    logic [ValBits-1:0]  mn, mx, av, cn;
    logic                vld;
    logic                ov_reg;
    logic [55:0]         od_reg;
    logic [3:0]          ou_reg;
    logic                ol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 12'd1551;
            mg_reg  <= 13'd20;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                RegTxThreshold: thr_reg <= cfg_wdata[11:0];
                RegMinGated:    mg_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;

    grdws_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_tlast),
        .in_ready(s_tready), .out_load(out_load), .out_free(out_free),
        .sts(sts), .cmd(cmd)
    );

    grdws_dp #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_FRAMES(MAX_FRAMES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .fwd(s_tdata[W-1:0]), .pos(s_tdata[2*W-1:W]), .neg(s_tdata[3*W-1:2*W]),
        .rev(s_tdata[4*W-1:3*W]), .temp(s_tdata[5*W-1:4*W]),
        .thr(thr_reg), .min_gated(mg_reg),
        .min_o(mn), .max_o(mx), .avg_o(av), .cnt_o(cn), .valid_o(vld)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (out_load) ov_reg <= 1'b1;
        else if (m_tready) ov_reg <= 1'b0;
        if (out_load) begin
            od_reg <= {4'b0, cn, av, mx, mn};
            ou_reg <= {vld, cmd.sel};
            ol_reg <= (cmd.sel == 3'(NumCh - 1));
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
    assign m_tlast  = ol_reg;
endmodule

// ===== rtl/core/grdws_div.sv =====
// restoring divider, one quotient bit per cycle, sign-magnitude
module grdws_div import grdws_pkg::*; #(
    parameter int NB = 32,
    parameter int DB = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NB-1:0] num,
    input  logic [DB-1:0]        den,
    output logic                 done,
    output logic signed [NB-1:0] quo
);
    localparam int CB = $clog2(NB + 1);
    logic [NB-1:0] q_reg, q_next;
    logic [DB:0]   r_reg, r_next;
    logic [DB-1:0] d_reg;
    logic          neg_reg;
    logic [CB-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DB:0]   trial;

    always_comb begin
        trial  = {r_reg[DB-1:0], q_reg[NB-1]};
        r_next = trial;
        q_next = {q_reg[NB-2:0], 1'b0};
        if (trial >= {1'b0, d_reg}) begin
            r_next    = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(NB);
                q_reg    <= num[NB-1] ? NB'(-num) : NB'(num);
                neg_reg  <= num[NB-1];
                r_reg    <= '0;
                d_reg    <= den;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

// ===== rtl/core/grdws_dp.sv =====
module grdws_dp import grdws_pkg::*; #(
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int MAX_FRAMES  = MaxFramesDef
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  grdws_cmd_t             cmd,
    output grdws_sts_t             sts,
    input  logic [SAMPLE_BITS-1:0] fwd, pos, neg, rev, temp,
    input  logic [11:0]            thr,
    input  logic [CfgBits-1:0]     min_gated,
    output logic [ValBits-1:0]     min_o, max_o, avg_o, cnt_o,
    output logic                   valid_o
);
    localparam int CntB = $clog2(MAX_FRAMES + 1);
    localparam int VB   = SAMPLE_BITS + 1;
    localparam int SB   = VB + CntB;

    logic signed [VB-1:0] mn_reg [NumCh];
    logic signed [VB-1:0] mx_reg [NumCh];
    logic signed [SB-1:0] sm_reg [NumCh];
    logic [CntB-1:0]      gc_reg, tc_reg;
    logic signed [VB-1:0] v [NumCh];
    logic signed [VB-1:0] dsum;
    logic                 gate, gtake, ttake;
    logic [CntB-1:0]      n;
    logic signed [SB-1:0] quo;
    logic                 ddone;

    always_comb begin
        v[0] = $signed({1'b0, fwd});
        v[1] = $signed({1'b0, pos});
        v[2] = $signed({1'b0, neg});
        v[3] = $signed({1'b0, rev});
        dsum = v[1] - v[2];
        v[ChDiff] = $signed(dsum + VB'(dsum[VB-1])) >>> 1;
        v[ChTemp] = $signed({1'b0, temp});
        gate  = (32'(fwd) < 32'(thr)) || (32'(rev) < 32'(thr));
        gtake = cmd.accum && gate && (32'(gc_reg) < 32'(MAX_FRAMES));
        ttake = cmd.accum && (32'(tc_reg) < 32'(MAX_FRAMES));
        n = (cmd.sel == 3'(ChTemp)) ? tc_reg : gc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            gc_reg <= '0;
            tc_reg <= '0;
            for (int c = 0; c < NumCh; c++) begin
                mn_reg[c] <= '1;
                mx_reg[c] <= '0;
                sm_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NumCh; c++) begin
                if ((c == ChTemp) ? ttake : gtake) begin
                    if (((c == ChTemp) ? tc_reg : gc_reg) == '0 || v[c] < mn_reg[c])
                        mn_reg[c] <= v[c];
                    if (((c == ChTemp) ? tc_reg : gc_reg) == '0 || v[c] > mx_reg[c])
                        mx_reg[c] <= v[c];
                    sm_reg[c] <= sm_reg[c] + SB'(v[c]);
                end
            end
            if (gtake) gc_reg <= gc_reg + 1'b1;
            if (ttake) tc_reg <= tc_reg + 1'b1;
        end
    end

    grdws_div #(.NB(SB), .DB(CntB)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(sm_reg[cmd.sel]), .den(n), .done(ddone), .quo(quo)
    );

    assign sts.div_done = ddone;
    assign min_o   = (n == '0) ? '0 : ValBits'(mn_reg[cmd.sel]);
    assign max_o   = (n == '0) ? '0 : ValBits'(mx_reg[cmd.sel]);
    assign avg_o   = (n == '0) ? '0 : ValBits'(quo);
    assign cnt_o   = ValBits'(n);
    assign valid_o = 32'(gc_reg) >= 32'(min_gated);
endmodule

// ===== rtl/core/grdws_ctrl.sv =====
module grdws_ctrl import grdws_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_load,
    input  logic       out_free,
    input  grdws_sts_t sts,
    output grdws_cmd_t cmd
);
    typedef enum logic [1:0] {S_ACC, S_DIV, S_WAIT, S_OUT} state_t;
    state_t     st_reg;
    logic [2:0] sel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_ACC;
            sel_reg <= '0;
        end else begin
            unique case (st_reg)
                S_ACC:  if (in_fire && in_last) begin
                    st_reg  <= S_DIV;
                    sel_reg <= '0;
                end
                S_DIV:  st_reg <= S_WAIT;
                S_WAIT: if (sts.div_done) st_reg <= S_OUT;
                S_OUT:  if (out_free) begin
                    if (sel_reg == 3'(NumCh - 1)) st_reg <= S_ACC;
                    else begin
                        sel_reg <= sel_reg + 1'b1;
                        st_reg  <= S_DIV;
                    end
                end
                default: st_reg <= S_ACC;
            endcase
        end
    end

    assign in_ready      = (st_reg == S_ACC);
    assign out_load      = (st_reg == S_OUT) && out_free;
    assign cmd.accum     = in_fire;
    assign cmd.div_start = (st_reg == S_DIV);
    assign cmd.sel       = sel_reg;
    assign cmd.clear     = out_load && (sel_reg == 3'(NumCh - 1));
endmodule

// ===== rtl/core/grdws_checker.sv =====
module grdws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
        else $error("output changed under stall");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[2:0] == 3'd5)))
        else $error("tlast not on channel 5");
    a_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:0] != 3'd6 && m_tuser[2:0] != 3'd7)
        else $error("bad channel");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken mid report");
endmodule

bind gated_rf_detector_window_stats grdws_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
